>>> design/sta_pkg.sv
package sta_pkg;
	localparam int unsigned MaxEntries = 16;
	localparam int unsigned IdxW = 4;
	localparam int unsigned CntW = 5;

	typedef enum logic [3:0] {
		MODE_JOIN = 4'd0, MODE_TOUCH = 4'd1, MODE_ACK = 4'd2, MODE_FIRE = 4'd3,
		MODE_REMOVE = 4'd4, MODE_EXPIRE = 4'd5, MODE_LOOKUP_EP = 4'd6,
		MODE_LOOKUP_PL = 4'd7, MODE_READ_SLOT = 4'd8
	} mode_t;

	localparam logic [1:0] REG_FIRE_COOLDOWN = 2'd0;
	localparam logic [1:0] REG_SESSION_TIMEOUT = 2'd1;

	typedef struct packed {
		logic [3:0]  mode;
		logic [47:0] peer_endpoint;
		logic [4:0]  player_key;
		logic [31:0] cur_tick;
		logic [31:0] value_tick;
		logic [3:0]  slot_index;
	} item_t;

	typedef struct packed {
		logic [4:0]  player_out;
		logic        ok;
		logic [47:0] endpoint_out;
		logic [31:0] input_tick_out;
		logic [31:0] acked_tick_out;
		logic [4:0]  entry_count;
		logic        last;
	} result_t;

	typedef struct packed {
		logic [1:0]  index;
		logic [31:0] data;
	} cfg_t;
endpackage

>>> design/sta_if.sv
interface sta_item_if;
	logic valid;
	logic ready;
	sta_pkg::item_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface sta_result_if;
	logic valid;
	logic ready;
	sta_pkg::result_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface sta_cfg_if;
	logic valid;
	logic ready;
	sta_pkg::cfg_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

>>> design/session_table_with_aging.sv
// Channel   Dir  Payload
// in_ch     in   item_t: mode, peer_endpoint, player_key, cur_tick, value_tick, slot_index
// out_ch    out  result_t: player_out, ok, endpoint/tick outputs, entry_count, last
// cfg_ch    in   cfg_t: index (0 cooldown, 1 timeout), data; always ready
// A sequencer steps one slot per cycle through the live entries with one compare unit.
// Most modes scan the live entries in order and then load their result (a hit ends
// the scan early); read slot and undefined modes go to the result without a scan.
// Expire first counts timed-out sessions over the live slots, then rescans, emitting and
// removing each timed-out session in turn, plus any wait on the output register.
// The input is held off until the item's last result is taken. Reset clears all entries.
module session_table_with_aging (
	input  logic clk,
	input  logic arst_n,
	sta_item_if.sink     in_ch,
	sta_result_if.source out_ch,
	sta_cfg_if.sink      cfg_ch
);
	import sta_pkg::*;

	typedef enum logic [1:0] {S_IDLE, S_SCAN, S_ACT, S_MOVE} state_t;

	state_t state_q;
	item_t item_q;
	logic [47:0] peer_q [MaxEntries];
	logic [4:0]  pl_q [MaxEntries];
	logic [31:0] seen_q [MaxEntries];
	logic [31:0] inp_q [MaxEntries];
	logic [31:0] ack_q [MaxEntries];
	logic [31:0] fire_q [MaxEntries];
	logic [MaxEntries-1:0] fired_q;
	logic [MaxEntries-1:0] used_q;
	logic [CntW-1:0] live_q, idx_q, exp_cnt_q, fin_q, sent_q;
	logic [IdxW-1:0] hit_q;
	logic found_q, purge_q;
	logic [31:0] cool_q, tmo_q;
	result_t res_q;
	logic ovalid_q;

	logic [IdxW-1:0] ix, hx, tx, nx;
	logic [CntW-1:0] pl_m1, free_id;
	logic [31:0] elapsed, since_fire;
	logic match, grant, new_join, out_free, do_move, emit, mv_last;
	result_t act_res, res_d;

	assign ix = idx_q[IdxW-1:0];
	assign hx = hit_q;
	assign tx = live_q[IdxW-1:0] - 1'b1;
	assign nx = live_q[IdxW-1:0];
	assign pl_m1 = pl_q[ix] - 1'b1;
	assign elapsed = (item_q.cur_tick >= seen_q[ix]) ? item_q.cur_tick - seen_q[ix] : '0;
	assign since_fire = item_q.cur_tick - fire_q[hx];
	assign grant = !(fired_q[hx] && since_fire < cool_q);
	assign new_join = item_q.mode == MODE_JOIN && !found_q && live_q < CntW'(MaxEntries);
	assign out_free = !ovalid_q || out_ch.ready;
	assign mv_last = sent_q + 1'b1 == exp_cnt_q;
	assign do_move = (state_q == S_ACT && item_q.mode == MODE_REMOVE && found_q) ||
		(state_q == S_MOVE && out_free);
	assign emit = state_q == S_ACT || (state_q == S_MOVE && out_free);

	// shared compare unit for the current slot
	always_comb begin
		unique case (item_q.mode) inside
			MODE_FIRE, MODE_LOOKUP_PL: match = item_q.player_key != '0 &&
				pl_q[ix] == item_q.player_key;
			MODE_EXPIRE: match = elapsed >= tmo_q;
			default: match = peer_q[ix] == item_q.peer_endpoint;
		endcase
	end

	// lowest player id that no scanned entry uses
	always_comb begin
		free_id = '0;
		for (int j = MaxEntries - 1; j >= 0; j--)
			if (!used_q[j]) free_id = CntW'(j + 1);
	end

	// final result of a single-result item
	always_comb begin
		act_res = '0;
		act_res.entry_count = live_q;
		act_res.last = 1'b1;
		unique case (item_q.mode) inside
			MODE_JOIN: if (found_q) begin
				act_res.player_out = pl_q[hx]; act_res.ok = pl_q[hx] != '0;
			end else if (new_join) begin
				act_res.player_out = free_id; act_res.ok = free_id != '0;
				act_res.entry_count = live_q + 1'b1;
			end
			MODE_TOUCH, MODE_ACK: if (found_q) begin
				act_res.player_out = pl_q[hx]; act_res.ok = 1'b1;
			end
			MODE_FIRE: if (found_q) begin
				act_res.player_out = pl_q[hx]; act_res.ok = grant;
			end
			MODE_REMOVE: if (found_q) begin
				act_res.player_out = pl_q[hx]; act_res.ok = 1'b1;
				act_res.entry_count = live_q - 1'b1;
			end
			MODE_LOOKUP_EP: if (found_q) begin
				act_res.player_out = pl_q[hx];
				act_res.ok = item_q.player_key != '0 && pl_q[hx] == item_q.player_key;
				act_res.endpoint_out = peer_q[hx];
				act_res.input_tick_out = inp_q[hx]; act_res.acked_tick_out = ack_q[hx];
			end
			MODE_LOOKUP_PL: if (found_q) begin
				act_res.player_out = pl_q[hx]; act_res.ok = 1'b1;
				act_res.endpoint_out = peer_q[hx];
				act_res.input_tick_out = inp_q[hx]; act_res.acked_tick_out = ack_q[hx];
			end
			MODE_READ_SLOT: begin
				act_res.player_out = pl_q[item_q.slot_index];
				act_res.ok = CntW'(item_q.slot_index) < live_q;
				act_res.endpoint_out = peer_q[item_q.slot_index];
				act_res.input_tick_out = inp_q[item_q.slot_index];
				act_res.acked_tick_out = ack_q[item_q.slot_index];
			end
			default: ;
		endcase
	end

	// expired session result, or the single-result item's result
	always_comb begin
		res_d = act_res;
		if (state_q == S_MOVE) begin
			res_d = '0;
			res_d.player_out = pl_q[hx]; res_d.ok = 1'b1;
			res_d.entry_count = fin_q; res_d.last = mv_last;
		end
	end

	assign in_ch.ready = state_q == S_IDLE && !ovalid_q;
	assign cfg_ch.ready = 1'b1;
	assign out_ch.valid = ovalid_q;
	assign out_ch.payload = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			item_q <= '0;
			live_q <= '0; idx_q <= '0; exp_cnt_q <= '0; fin_q <= '0; sent_q <= '0;
			hit_q <= '0; found_q <= 1'b0; purge_q <= 1'b0;
			used_q <= '0; fired_q <= '0;
			cool_q <= 32'd10; tmo_q <= 32'd300;
			res_q <= '0; ovalid_q <= 1'b0;
			for (int i = 0; i < MaxEntries; i++) begin
				peer_q[i] <= '0; pl_q[i] <= '0; seen_q[i] <= '0;
				inp_q[i] <= '0; ack_q[i] <= '0; fire_q[i] <= '0;
			end
		end else begin
			if (cfg_ch.valid) begin
				if (cfg_ch.payload.index == REG_FIRE_COOLDOWN) cool_q <= cfg_ch.payload.data;
				else if (cfg_ch.payload.index == REG_SESSION_TIMEOUT)
					tmo_q <= cfg_ch.payload.data;
			end
			// output register
			if (emit) begin
				res_q <= res_d; ovalid_q <= 1'b1;
			end else if (out_ch.ready) ovalid_q <= 1'b0;
			// removal: move last entry into the freed slot, clear the old last slot
			if (do_move) begin
				if (hx != tx) begin
					peer_q[hx] <= peer_q[tx]; pl_q[hx] <= pl_q[tx];
					seen_q[hx] <= seen_q[tx]; inp_q[hx] <= inp_q[tx];
					ack_q[hx] <= ack_q[tx]; fire_q[hx] <= fire_q[tx];
					fired_q[hx] <= fired_q[tx];
				end
				peer_q[tx] <= '0; pl_q[tx] <= '0; seen_q[tx] <= '0;
				inp_q[tx] <= '0; ack_q[tx] <= '0; fire_q[tx] <= '0; fired_q[tx] <= 1'b0;
				live_q <= live_q - 1'b1;
			end
			unique case (state_q)
				S_IDLE: if (in_ch.valid && in_ch.ready) begin
					item_q <= in_ch.payload;
					idx_q <= '0; found_q <= 1'b0; purge_q <= 1'b0; used_q <= '0;
					exp_cnt_q <= '0; sent_q <= '0;
					state_q <= S_SCAN;
				end
				// one slot per cycle; expire's removal pass pauses in S_MOVE on each hit
				S_SCAN: begin
					if (item_q.mode >= MODE_READ_SLOT) state_q <= S_ACT;
					else if (item_q.mode == MODE_EXPIRE) begin
						// first pass counts, second pass removes
						if (idx_q >= live_q) begin
							if (purge_q) state_q <= S_IDLE;
							else if (exp_cnt_q == '0) state_q <= S_ACT;
							else begin
								purge_q <= 1'b1; idx_q <= '0;
								fin_q <= live_q - exp_cnt_q;
							end
						end else if (purge_q) begin
							if (match) begin
								hit_q <= ix; state_q <= S_MOVE;
							end else idx_q <= idx_q + 1'b1;
						end else begin
							if (match) exp_cnt_q <= exp_cnt_q + 1'b1;
							idx_q <= idx_q + 1'b1;
						end
					end else if (idx_q >= live_q) state_q <= S_ACT;
					else if (match) begin
						hit_q <= ix; found_q <= 1'b1; state_q <= S_ACT;
					end else begin
						used_q[pl_m1[IdxW-1:0]] <= 1'b1;
						idx_q <= idx_q + 1'b1;
					end
				end
				S_ACT: begin
					unique case (item_q.mode)
						MODE_JOIN: if (new_join) begin
							// new session in slot live_q
							peer_q[nx] <= item_q.peer_endpoint;
							pl_q[nx] <= free_id;
							seen_q[nx] <= item_q.cur_tick;
							inp_q[nx] <= '0; ack_q[nx] <= '0;
							fire_q[nx] <= '0; fired_q[nx] <= 1'b0;
							live_q <= live_q + 1'b1;
						end
						MODE_TOUCH: if (found_q) begin
							seen_q[hx] <= item_q.cur_tick;
							if (item_q.value_tick > inp_q[hx]) inp_q[hx] <= item_q.value_tick;
						end
						MODE_ACK: if (found_q) begin
							if (item_q.value_tick > ack_q[hx]) ack_q[hx] <= item_q.value_tick;
						end
						MODE_FIRE: if (found_q && grant) begin
							fire_q[hx] <= item_q.cur_tick; fired_q[hx] <= 1'b1;
						end
						default: ;
					endcase
					state_q <= S_IDLE;
				end
				// expire: emit id, remove, re-check the same slot
				S_MOVE: if (out_free) begin
					sent_q <= sent_q + 1'b1;
					state_q <= mv_last ? S_IDLE : S_SCAN;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
